### hdl/kslp_pkg.sv
// Package for the short/long key press detector.
// Holds shared widths, register reset values, register indexes and the event type.
// No dependencies.
package kslp_pkg;

    localparam int KEY_W        = 4;
    localparam int CNT_W        = 16;
    localparam int NUM_KEYS_DEF = 4;
    localparam int TDATA_W      = 8;

    localparam logic [CNT_W-1:0] LONG_LIMIT_RST  = 16'd100;
    localparam logic [CNT_W-1:0] SHORT_LIMIT_RST = 16'd3;
    localparam logic [CNT_W-1:0] CNT_MAX         = '1;

    typedef enum logic [0:0] {
        CFG_LONG_LIMIT  = 1'b0,
        CFG_SHORT_LIMIT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [KEY_W-1:0] keys;
        logic             long_press;
    } t_event;

endpackage

### hdl/key_short_long_press_detector.sv
// Short/long key press detector, top level.
// Each input transfer is one scan tick carrying four active-low key pin levels.
// Every tick yields exactly one result transfer: a key mask and a long flag,
// both zero when the tick produced no event.
// A long press is reported once the hold counter exceeds long_limit while keys
// stay down; a short press is reported on release if the counter reached
// short_limit and nothing was reported during that press.
// Channels: slave stream s_axis (tdata = key levels), master stream m_axis
// (tdata = event keys, tuser = long flag), and a config write channel with a
// register index (0 = long_limit, 1 = short_limit) and 16-bit data.
// Each result is registered in the output buffer before it appears on m_axis.
// Throughput: one tick per cycle while s_axis_tready is high; the state update is
// counter compares and flag updates between the input and the result register.
// When the receiver stalls, one result is held and one more goes to a skid
// stage; s_axis_tready falls only while both are occupied.
// Reset (synchronous, active low) clears the press state and output buffer
// and loads long_limit = 100 and short_limit = 3.
// Depends on kslp_pkg, kslp_core and kslp_out_buf.
module key_short_long_press_detector #(
    parameter int NUM_KEYS = kslp_pkg::NUM_KEYS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input stream.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [kslp_pkg::TDATA_W-1:0] s_axis_tdata,  // [3:0] key_levels, [7:4] zero
    // Result stream.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [kslp_pkg::TDATA_W-1:0] m_axis_tdata,  // [3:0] event_keys, [7:4] zero
    output logic                         m_axis_tuser,  // [0] long_press
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [kslp_pkg::CNT_W-1:0]   i_cfg_data
);
    import kslp_pkg::*;

    logic [CNT_W-1:0] r_long_limit;
    logic [CNT_W-1:0] r_short_limit;
    logic             push;
    t_event           core_event;
    t_event           out_event;

    // Configuration is always taken; it is only to be written by the user while the block is idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_limit  <= LONG_LIMIT_RST;
            r_short_limit <= SHORT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LONG_LIMIT:  r_long_limit  <= i_cfg_data;
                CFG_SHORT_LIMIT: r_short_limit <= i_cfg_data;
                default:         r_long_limit  <= r_long_limit;
            endcase
        end
    end

    // A tick advances the press state exactly when it is transferred in.
    assign push = s_axis_tvalid & s_axis_tready;

    kslp_core #(
        .NUM_KEYS (NUM_KEYS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_key_levels  (s_axis_tdata[KEY_W-1:0]),
        .i_long_limit  (r_long_limit),
        .i_short_limit (r_short_limit),
        .o_event       (core_event)
    );

    kslp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_event (core_event),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_event (out_event)
    );

    assign m_axis_tdata = {{(TDATA_W-KEY_W){1'b0}}, out_event.keys};
    assign m_axis_tuser = out_event.long_press;

endmodule

### hdl/kslp_core.sv
// Press tracking state and per-tick event decision for the key press detector.
// Depends on kslp_pkg.
module kslp_core #(
    parameter int NUM_KEYS = kslp_pkg::NUM_KEYS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [kslp_pkg::KEY_W-1:0] i_key_levels,
    input  logic [kslp_pkg::CNT_W-1:0] i_long_limit,
    input  logic [kslp_pkg::CNT_W-1:0] i_short_limit,
    output kslp_pkg::t_event           o_event
);
    import kslp_pkg::*;

    // Only the low NUM_KEYS pins count, never more than the field holds.
    localparam int KeyBits = (NUM_KEYS > KEY_W) ? KEY_W : NUM_KEYS;
    localparam logic [KEY_W-1:0] KeyMask = KEY_W'((1 << KeyBits) - 1);

    logic             r_armed, n_armed;
    logic             r_reported, n_reported;
    logic [KEY_W-1:0] r_held, n_held;
    logic [CNT_W-1:0] r_count, n_count;
    logic [KEY_W-1:0] keys;

    assign keys = ~i_key_levels & KeyMask;

    always_comb begin
        n_armed    = r_armed;
        n_reported = r_reported;
        n_held     = r_held;
        n_count    = r_count;
        o_event    = '0;
        if (!r_armed) begin
            if (keys != '0) begin
                n_reported = 1'b0;
                n_armed    = 1'b1;
                n_count    = '0;
            end
        end else if (keys != '0) begin
            n_held = keys;
            if (r_count > i_long_limit) begin
                if (!r_reported) begin
                    n_reported         = 1'b1;
                    n_count            = '0;
                    o_event.keys       = keys;
                    o_event.long_press = 1'b1;
                end
            end else if (r_count != CNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end else begin
            // Release: short press, last held mask, if count >= short_limit.
            n_held  = '0;
            n_armed = 1'b0;
            if ((r_count >= i_short_limit) && !r_reported) begin
                n_reported   = 1'b1;
                o_event.keys = r_held;
            end
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_reported <= 1'b0;
            r_held     <= '0;
            r_count    <= '0;
        end else if (i_push) begin
            r_armed    <= n_armed;
            r_reported <= n_reported;
            r_held     <= n_held;
            r_count    <= n_count;
        end
    end

endmodule

### hdl/kslp_out_buf.sv
// Output register with a skid stage for the key press detector results.
// Depends on kslp_pkg.
module kslp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  kslp_pkg::t_event i_event,
    output logic             o_valid,
    input  logic             i_ready,
    output kslp_pkg::t_event o_event
);
    import kslp_pkg::*;

    logic   r_main_v, r_skid_v;
    t_event r_main, r_skid;
    logic   pop, push;

    assign pop     = r_main_v & i_ready;
    assign push    = i_valid & ~r_skid_v;
    assign o_ready = ~r_skid_v;
    assign o_valid = r_main_v;
    assign o_event = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (push) begin
            if (!r_main_v || pop) begin
                r_main_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (pop) begin
            r_main_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (push) begin
            if (!r_main_v || pop) begin
                r_main <= i_event;
            end else begin
                r_skid <= i_event;
            end
        end
    end

endmodule
